@@ hw/rtl/pfe_pkg.sv @@
// ============================================================================
// pfe_pkg - shared types and constants for the Playfair encryptor
// Command codes, letter constants and 5x5 square helper functions.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

    // input mode codes (s_tuser)
    localparam logic [2:0] MODE_NEW_KEY   = 3'd0;
    localparam logic [2:0] MODE_KEY_CHAR  = 3'd1;
    localparam logic [2:0] MODE_KEY_DONE  = 3'd2;
    localparam logic [2:0] MODE_MSG_CHAR  = 3'd3;
    localparam logic [2:0] MODE_MSG_END   = 3'd4;

    // internal command codes passed through the queue
    localparam logic [2:0] OP_NEW_KEY     = 3'd0;
    localparam logic [2:0] OP_KEY_CHAR    = 3'd1;
    localparam logic [2:0] OP_KEY_DONE    = 3'd2;
    localparam logic [2:0] OP_MSG_CHAR    = 3'd3;
    localparam logic [2:0] OP_MSG_END     = 3'd4;

    localparam logic [4:0] LETTER_I       = 5'd8;
    localparam logic [4:0] LETTER_J       = 5'd9;
    localparam logic [4:0] LETTER_X       = 5'd23;
    localparam logic [4:0] LAST_LETTER    = 5'd25;
    localparam logic [4:0] NUM_CELLS      = 5'd25;
    localparam logic [6:0] ASCII_A        = 7'd65;
    localparam logic [7:0] ASCII_A8       = 8'd65;
    localparam logic [7:0] ASCII_Z8       = 8'd90;
    localparam logic [7:0] ASCII_LA8      = 8'd97;
    localparam logic [7:0] ASCII_LZ8      = 8'd122;
    localparam logic [7:0] CASE_OFFSET    = 8'd32;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;

    typedef struct packed {
        logic [2:0] op;
        letter_t    letter;
    } pfe_cmd_t;

    typedef struct packed {
        logic     valid;
        pfe_cmd_t cmd;
    } pfe_head_t;

    typedef struct packed {
        logic    is_letter;
        letter_t idx;
    } letter_info_t;

    // upper-case, fold J into I, flag non-letters
    function automatic letter_info_t letter_of(input logic [7:0] code);
        logic [7:0]   c;
        letter_info_t r;
        c = code;
        if (c >= ASCII_LA8 && c <= ASCII_LZ8) begin
            c = c - CASE_OFFSET;
        end
        r.is_letter = (c >= ASCII_A8) && (c <= ASCII_Z8);
        r.idx       = 5'(c - ASCII_A8);
        if (r.idx == LETTER_J) begin
            r.idx = LETTER_I;
        end
        return r;
    endfunction

    function automatic coord_t cell_row(input cell_t c);
        coord_t r;
        if (c >= 5'd20) begin
            r = 3'd4;
        end else if (c >= 5'd15) begin
            r = 3'd3;
        end else if (c >= 5'd10) begin
            r = 3'd2;
        end else if (c >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic coord_t cell_col(input cell_t c);
        cell_t d;
        d = c - ({2'b00, cell_row(c)} * 5'd5);
        return d[2:0];
    endfunction

    function automatic cell_t cell_at(input coord_t row, input coord_t col);
        return ({2'b00, row} * 5'd5) + {2'b00, col};
    endfunction

    function automatic coord_t wrap_inc(input coord_t v);
        return (v == 3'd4) ? 3'd0 : v + 3'd1;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pfe_front.sv @@
// ============================================================================
// pfe_front - input classifier and command queue
// Decodes each input transaction, drops items that carry no work and queues
// the rest for the back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pfe_front #(
    parameter int DEPTH = 4
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  wire  [7:0]        s_tdata,   // [7:0] char_code
    input  wire  [2:0]        s_tuser,   // [2:0] mode
    output pfe_pkg::pfe_head_t head,
    input  wire               pop
);
    import pfe_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    pfe_cmd_t     mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    letter_info_t info;
    pfe_cmd_t     cmd;
    logic         keep;
    logic         push;

    always_comb begin
        info       = letter_of(s_tdata);
        cmd.letter = info.idx;
        cmd.op     = OP_NEW_KEY;
        keep       = 1'b0;
        unique case (s_tuser)
            MODE_NEW_KEY: begin
                cmd.op = OP_NEW_KEY;
                keep   = 1'b1;
            end
            MODE_KEY_CHAR: begin
                cmd.op = OP_KEY_CHAR;
                keep   = info.is_letter;
            end
            MODE_KEY_DONE: begin
                cmd.op = OP_KEY_DONE;
                keep   = 1'b1;
            end
            MODE_MSG_CHAR: begin
                cmd.op = OP_MSG_CHAR;
                keep   = info.is_letter;
            end
            MODE_MSG_END: begin
                cmd.op = OP_MSG_END;
                keep   = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = (count_reg != CW'(DEPTH));
    assign push     = s_tvalid && s_tready && keep;

    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= cmd;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pfe_back.sv @@
// ============================================================================
// pfe_back - key square builder and pair encryptor
// Holds the 5x5 square, executes queued commands and drives the cipher
// letters one transaction at a time.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pfe_back (
    input  wire                aclk,
    input  wire                aresetn,
    input  pfe_pkg::pfe_head_t head,
    output logic               pop,
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [7:0]         m_tdata,   // [6:0] cipher_char, [7] zero
    output logic               m_tlast    // last_of_pair
);
    import pfe_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILL  = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_EMIT0 = 3'd3;
    localparam logic [2:0] ST_EMIT1 = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [25:0] used_reg, used_next;
    cell_t       fill_reg, fill_next;
    logic        key_ready_reg, key_ready_next;
    letter_t     pend_reg, pend_next;
    logic        pend_valid_reg, pend_valid_next;
    letter_t     walk_reg, walk_next;

    letter_t     cell_letter_mem [25];
    cell_t       letter_cell_mem [26];
    cell_t       lc_a_reg, lc_b_reg;
    letter_t     cl_a_reg, cl_b_reg;

    letter_t     place_idx;
    logic        place_ok;
    logic        place_en;
    logic        pair_start;
    letter_t     rd_b;
    coord_t      ra, ca, rb, cb;
    cell_t       oa, ob;
    letter_t     out_letter;

    assign pop       = (state_reg == ST_IDLE) && head.valid;
    assign place_idx = (state_reg == ST_FILL) ? walk_reg : head.cmd.letter;
    assign place_ok  = !used_reg[place_idx] && (fill_reg < NUM_CELLS);
    assign place_en  = ((state_reg == ST_IDLE) && head.valid && (head.cmd.op == OP_KEY_CHAR)
                        && !key_ready_reg && place_ok)
                     || ((state_reg == ST_FILL) && (walk_reg != LETTER_J) && place_ok);

    // a pair opens a lookup when the second letter or the message end arrives
    assign pair_start = pop && key_ready_reg && pend_valid_reg
                        && ((head.cmd.op == OP_MSG_CHAR) || (head.cmd.op == OP_MSG_END));
    assign rd_b       = (head.cmd.op == OP_MSG_END) ? LETTER_X : head.cmd.letter;

    // square geometry of the two looked-up cells
    always_comb begin
        ra = cell_row(lc_a_reg);
        ca = cell_col(lc_a_reg);
        rb = cell_row(lc_b_reg);
        cb = cell_col(lc_b_reg);
        if (ra == rb) begin
            oa = cell_at(ra, wrap_inc(ca));
            ob = cell_at(rb, wrap_inc(cb));
        end else if (ca == cb) begin
            oa = cell_at(wrap_inc(ra), ca);
            ob = cell_at(wrap_inc(rb), cb);
        end else begin
            oa = cell_at(ra, cb);
            ob = cell_at(rb, ca);
        end
    end

    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        fill_next       = fill_reg;
        key_ready_next  = key_ready_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        walk_next       = walk_reg;

        if (place_en) begin
            used_next[place_idx] = 1'b1;
            fill_next            = fill_reg + 5'd1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    unique case (head.cmd.op)
                        OP_NEW_KEY: begin
                            used_next       = '0;
                            fill_next       = '0;
                            key_ready_next  = 1'b0;
                            pend_next       = '0;
                            pend_valid_next = 1'b0;
                        end
                        OP_KEY_CHAR: begin
                        end
                        OP_KEY_DONE: begin
                            walk_next  = '0;
                            state_next = ST_FILL;
                        end
                        OP_MSG_CHAR: begin
                            if (key_ready_reg) begin
                                if (pend_valid_reg) begin
                                    pend_next       = '0;
                                    pend_valid_next = 1'b0;
                                    state_next      = ST_LOOK;
                                end else begin
                                    pend_next       = head.cmd.letter;
                                    pend_valid_next = 1'b1;
                                end
                            end
                        end
                        OP_MSG_END: begin
                            if (key_ready_reg && pend_valid_reg) begin
                                pend_next       = '0;
                                pend_valid_next = 1'b0;
                                state_next      = ST_LOOK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                // walk A..Z once, placing every letter except J not yet in the square
                if (walk_reg == LAST_LETTER) begin
                    key_ready_next = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    walk_next = walk_reg + 5'd1;
                end
            end
            ST_LOOK: begin
                state_next = ST_EMIT0;
            end
            ST_EMIT0: begin
                if (m_tready) begin
                    state_next = ST_EMIT1;
                end
            end
            ST_EMIT1: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            fill_reg       <= '0;
            key_ready_reg  <= 1'b0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            walk_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            fill_reg       <= fill_next;
            key_ready_reg  <= key_ready_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            walk_reg       <= walk_next;
        end
    end

    // square memories: one write port each, two registered read ports
    always_ff @(posedge aclk) begin
        if (place_en) begin
            cell_letter_mem[fill_reg]  <= place_idx;
            letter_cell_mem[place_idx] <= fill_reg;
        end
        if (pair_start) begin
            lc_a_reg <= letter_cell_mem[pend_reg];
            lc_b_reg <= letter_cell_mem[rd_b];
        end
        if (state_reg == ST_LOOK) begin
            cl_a_reg <= cell_letter_mem[oa];
            cl_b_reg <= cell_letter_mem[ob];
        end
    end

    assign out_letter = (state_reg == ST_EMIT1) ? cl_b_reg : cl_a_reg;
    assign m_tvalid   = (state_reg == ST_EMIT0) || (state_reg == ST_EMIT1);
    assign m_tlast    = (state_reg == ST_EMIT1);
    assign m_tdata    = {1'b0, ASCII_A + {2'b00, out_letter}};

endmodule

`default_nettype wire

@@ hw/rtl/playfair_encryptor.sv @@
// ============================================================================
// playfair_encryptor - Playfair cipher, encryption direction
// Streaming key load, square completion and letter-pair encryption.
// ============================================================================
// Input side takes one transaction per cycle until the command queue is full.
// Key complete walks the alphabet to fill the square. A pair passes through
// the lookup and emit states and waits on output stalls; with the back end
// idle, the closing transaction is queued and popped, the square is read in
// the lookup state, and then the first cipher letter is offered.
// Reset clears all control state; the square contents are undefined until
// the next key complete.
`timescale 1ns / 1ps
`default_nettype none

module playfair_encryptor #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] char_code
    input  wire  [2:0] s_tuser,   // [2:0] mode
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [6:0] cipher_char, [7] zero
    output logic       m_tlast    // last_of_pair
);
    import pfe_pkg::*;

    pfe_head_t head;
    logic      pop;

    pfe_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    pfe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> head.valid)
        else $error("queue full yet reports no entry");

    a_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
        else $error("second letter of pair not presented");

    a_no_pop_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !pop)
        else $error("command consumed during output");

endmodule

`default_nettype wire
